/* src/ecbp_pkg.sv */
// Shared constants and state encodings for the error-code blink pattern core.
package ecbp_pkg;

    // Blink timing in milliseconds
    localparam int unsigned CYCLE_STEP = 600;
    localparam int unsigned BURST_STEP = 400;
    localparam int unsigned PULSE_MS   = 200;

    // Field and datapath widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned PERIOD_W = 18;   // 600*255-200 = 152800
    localparam int unsigned BURST_W  = 17;   // 400*255-200 = 101800
    localparam int unsigned CNT_W    = 5;    // counts the dividend bits of one pass
    localparam int unsigned STEP_W   = PERIOD_W + 1;

    // Steps of the long-division pass
    localparam int unsigned TIME_STEPS = TIME_W;

    // Quotient by 400 = 16 * 25: drop four bits, then multiply by ceil(2^18 / 25)
    localparam int unsigned PAIR_SHIFT  = 4;
    localparam int unsigned PAIR_RECIP  = 10486;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned QUO_W       = 9;    // 152799 / 400 = 381
    localparam int unsigned PROD_W      = RECIP_SHIFT + QUO_W;

    // Display phase
    typedef enum logic [2:0] {
        PH_WAITING  = 3'b001,
        PH_READY    = 3'b010,
        PH_BLINKING = 3'b100
    } phase_t;

    // Sequencer: shared divide step, quotient estimate, output hand-off
    typedef enum logic [3:0] {
        SEQ_IDLE = 4'b0001,
        SEQ_DIV  = 4'b0010,
        SEQ_MOD  = 4'b0100,
        SEQ_DONE = 4'b1000
    } seq_t;

endpackage

/* src/error_code_blink_pattern_core.sv */
// Error-code blink pattern core: phase tracking and a shared restoring divide step.
//
// Usage: each input word carries now_ms and error_code on a valid/ready channel.
// A zero code returns the block to waiting; the first two nonzero words warm it
// up (the second one latches the code). Neither produces an output word. After
// that, every nonzero word produces one led_on word on the output valid/ready
// channel. Words that produce no output are taken one per cycle while the
// sequencer is idle. A blinking word runs through one shared subtract-and-compare
// step: SEQ_DIV reduces now_ms modulo the period 600*e-200 one dividend bit at
// a time, SEQ_MOD estimates that remainder's quotient by 400 with a reciprocal
// multiply, and SEQ_DONE hands the level to the output register. in_ready is
// low while the sequencer works, so the next word waits until it is idle.
// The output register lets the next word be accepted while a result waits;
// if a new result is ready before the old one is taken, the sequencer holds
// in its final state until out_ready frees the register.
// Reset (rst_n low, asynchronous) empties the output, idles the sequencer and
// puts the phase back to waiting.
module error_code_blink_pattern_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ecbp_pkg::TIME_W-1:0]      now_ms,
    input  logic [ecbp_pkg::CODE_W-1:0]      error_code,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             led_on
);

    ecbp_pkg::seq_t   seq_reg,   seq_next;
    ecbp_pkg::phase_t phase_reg, phase_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            led_reg,       led_next;
    logic [ecbp_pkg::PERIOD_W-1:0]   period_reg,    period_next;
    logic [ecbp_pkg::BURST_W-1:0]    burst_reg,     burst_next;
    logic [ecbp_pkg::TIME_W-1:0]     dvd_reg,       dvd_next;
    logic [ecbp_pkg::PERIOD_W-1:0]   rem_reg,       rem_next;
    logic [ecbp_pkg::PERIOD_W-1:0]   m_reg,         m_next;
    logic [ecbp_pkg::QUO_W-1:0]      q_reg,         q_next;
    logic [ecbp_pkg::CNT_W-1:0]      cnt_reg,       cnt_next;

    logic [ecbp_pkg::STEP_W-1:0]     step_in;
    logic [ecbp_pkg::STEP_W-1:0]     divisor;
    logic [ecbp_pkg::STEP_W-1:0]     trial;
    logic [ecbp_pkg::PERIOD_W-1:0]   rem_step;
    logic [ecbp_pkg::PERIOD_W+1:0]   period_full;
    logic [ecbp_pkg::BURST_W+1:0]    burst_full;
    logic [ecbp_pkg::PROD_W-1:0]     q_prod;
    logic [ecbp_pkg::QUO_W-1:0]      q_est;
    logic [ecbp_pkg::PERIOD_W-1:0]   pair_rem;
    logic                            accept;
    logic                            led_level;

    assign in_ready  = (seq_reg == ecbp_pkg::SEQ_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign led_on    = led_reg;

    // Shared restoring step: shift in the next dividend bit, subtract if it fits
    assign step_in = {rem_reg, dvd_reg[ecbp_pkg::TIME_W-1]};
    assign divisor = {1'b0, period_reg};
    assign trial   = step_in - divisor;
    assign rem_step = (step_in >= divisor) ? trial[ecbp_pkg::PERIOD_W-1:0]
                                           : step_in[ecbp_pkg::PERIOD_W-1:0];

    // Period and burst length for a newly latched code
    assign period_full = (ecbp_pkg::PERIOD_W+2)'(error_code)
                       * (ecbp_pkg::PERIOD_W+2)'(ecbp_pkg::CYCLE_STEP)
                       - (ecbp_pkg::PERIOD_W+2)'(ecbp_pkg::PULSE_MS);
    assign burst_full  = (ecbp_pkg::BURST_W+2)'(error_code)
                       * (ecbp_pkg::BURST_W+2)'(ecbp_pkg::BURST_STEP)
                       - (ecbp_pkg::BURST_W+2)'(ecbp_pkg::PULSE_MS);

    // Quotient of the period remainder by the pulse pair length
    assign q_prod = ecbp_pkg::PROD_W'(m_reg[ecbp_pkg::PERIOD_W-1:ecbp_pkg::PAIR_SHIFT])
                  * ecbp_pkg::PROD_W'(ecbp_pkg::PAIR_RECIP);
    assign q_est  = q_prod[ecbp_pkg::RECIP_SHIFT +: ecbp_pkg::QUO_W];

    // Position inside the current pulse pair
    assign pair_rem = m_reg - ecbp_pkg::PERIOD_W'(q_reg)
                            * ecbp_pkg::PERIOD_W'(ecbp_pkg::BURST_STEP);

    // LED level from the two remainders
    assign led_level = (pair_rem <= ecbp_pkg::PERIOD_W'(ecbp_pkg::PULSE_MS))
                    && (m_reg <= {1'b0, burst_reg});

    // Sequencer and phase control
    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        led_next       = led_reg;
        period_next    = period_reg;
        burst_next     = burst_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        m_next         = m_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;

        case (seq_reg)
            ecbp_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (error_code == '0)
                    begin
                        phase_next = ecbp_pkg::PH_WAITING;
                    end
                    else
                    begin
                        case (phase_reg)
                            ecbp_pkg::PH_WAITING:
                            begin
                                phase_next = ecbp_pkg::PH_READY;
                            end
                            ecbp_pkg::PH_READY:
                            begin
                                period_next = period_full[ecbp_pkg::PERIOD_W-1:0];
                                burst_next  = burst_full[ecbp_pkg::BURST_W-1:0];
                                phase_next  = ecbp_pkg::PH_BLINKING;
                            end
                            ecbp_pkg::PH_BLINKING:
                            begin
                                dvd_next = now_ms;
                                rem_next = '0;
                                cnt_next = ecbp_pkg::CNT_W'(ecbp_pkg::TIME_STEPS - 1);
                                seq_next = ecbp_pkg::SEQ_DIV;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            ecbp_pkg::SEQ_DIV:
            begin
                // Reduce now_ms modulo the period, one bit a cycle
                rem_next = rem_step;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    m_next   = rem_step;
                    seq_next = ecbp_pkg::SEQ_MOD;
                end
            end
            ecbp_pkg::SEQ_MOD:
            begin
                // Hold the pulse pair count of the remainder
                q_next   = q_est;
                seq_next = ecbp_pkg::SEQ_DONE;
            end
            ecbp_pkg::SEQ_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    led_next       = led_level;
                    seq_next       = ecbp_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = ecbp_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ecbp_pkg::SEQ_IDLE;
            phase_reg     <= ecbp_pkg::PH_WAITING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        led_reg    <= led_next;
        period_reg <= period_next;
        burst_reg  <= burst_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        m_reg      <= m_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
    end

endmodule
